### rtl/core/rgbds_pkg.sv
// Shared constants, types and helpers for the 2x2 RGB box downsampler.
`timescale 1ns / 1ps

package rgbds_pkg;

   // Largest frame the line store and counters are sized for
   localparam int MAX_OUT_WIDTH  = 512;
   localparam int MAX_OUT_HEIGHT = 512;

   // Field and register widths
   localparam int PIX_W     = 8;
   localparam int PAIR_W    = PIX_W + 1;
   localparam int QUAD_W    = PIX_W + 2;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 4;

   // Counter and line store index widths
   localparam int SLOT_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int COL_W  = SLOT_W + 1;
   localparam int ROW_W  = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) + 1 : 1;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0]     OUT_WIDTH_RESET  = CFG_W'(320);
   localparam logic [CFG_W-1:0]     OUT_HEIGHT_RESET = CFG_W'(240);

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_type;

   // Force a size register into the range 1 .. maxv
   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int maxv);
      logic [CFG_W-1:0] res;
      if (v == '0) begin
         res = CFG_W'(1);
      end else if (32'(v) > maxv) begin
         res = CFG_W'(maxv);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Index of the last input pixel along an axis: 2 * size - 1
   function automatic logic [COL_W-1:0] last_col(input logic [CFG_W-1:0] size);
      logic [CFG_W:0] t;
      t = {size, 1'b0} - (CFG_W + 1)'(1);
      return COL_W'(t);
   endfunction

   function automatic logic [ROW_W-1:0] last_row(input logic [CFG_W-1:0] size);
      logic [CFG_W:0] t;
      t = {size, 1'b0} - (CFG_W + 1)'(1);
      return ROW_W'(t);
   endfunction

endpackage

### rtl/core/rgbds_req_if.sv
// Pixel input channel: valid, ready and one RGB pixel.
`timescale 1ns / 1ps

interface rgbds_req_if;
   import rgbds_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

### rtl/core/rgbds_rsp_if.sv
// Result channel: valid, ready, one averaged RGB pixel and the frame end flag.
`timescale 1ns / 1ps

interface rgbds_rsp_if;
   import rgbds_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_out;
   logic [PIX_W-1:0] green_out;
   logic [PIX_W-1:0] blue_out;
   logic             frame_end;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output frame_end, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input frame_end, output ready);
endinterface

### rtl/core/rgb_box_downsample_2x2.sv
// 2x2 box-filter downsampler for raster-order RGB pixels.
// Throughput: one input pixel per cycle unless the result channel stalls.
// Line store: one access per pixel pair. The pixel that completes its 2x2 block
//   (odd column, odd row) moves through the first stage into the result register.
// Reset: sizes go to 320 x 240, position and held pixel to zero, pipeline empties.
//   The line store is not cleared: each odd row reads only what its even row wrote.
`timescale 1ns / 1ps

module rgb_box_downsample_2x2 (
   input  logic                              clock,
   input  logic                              reset,
   rgbds_req_if.sink                         req_chan,
   rgbds_rsp_if.source                       rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rgbds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rgbds_pkg::CFG_W-1:0]       csr_wdata
);
   import rgbds_pkg::*;

   localparam int LINE_DEPTH = 1 << SLOT_W;

   // Configuration and position
   logic [CFG_W-1:0] out_width_ff, out_width_in;
   logic [CFG_W-1:0] out_height_ff, out_height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pixel_type        held_ff, held_in;

   // Pipeline registers
   logic             s1_valid_ff, s1_valid_in;
   pair_type         s1_pair_ff, s1_pair_in;
   logic             s1_last_ff, s1_last_in;
   pair_type         above_ff;
   logic             out_valid_ff, out_valid_in;
   pixel_type        out_pix_ff, out_pix_in;
   logic             out_last_ff, out_last_in;

   // Line store of horizontal pair sums from the even row
   pair_type         line_store_ff [LINE_DEPTH];

   logic             out_take;
   logic             s1_take;
   logic             accept;
   logic             csr_hit;
   logic [CFG_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff;
   logic             at_row_end;
   logic             at_frame_end;
   logic             emit;
   logic             store_wr;
   logic [SLOT_W-1:0] slot;
   pixel_type        pix;
   pair_type         pair;
   logic [QUAD_W-1:0] sum_red;
   logic [QUAD_W-1:0] sum_green;
   logic [QUAD_W-1:0] sum_blue;

   // Handshake: output register frees when empty or taken, first stage when it can move
   assign out_take       = !out_valid_ff || rsp_chan.ready;
   assign s1_take        = !s1_valid_ff || out_take;
   assign req_chan.ready = s1_take;
   assign accept         = req_chan.valid && s1_take;

   assign csr_hit = csr_wr_en && ((csr_index == CSR_OUT_WIDTH) ||
                                  (csr_index == CSR_OUT_HEIGHT));

   // Decode position within the frame
   assign width_eff    = clamp_size(out_width_ff, MAX_OUT_WIDTH);
   assign height_eff   = clamp_size(out_height_ff, MAX_OUT_HEIGHT);
   assign at_row_end   = (col_ff == last_col(width_eff));
   assign at_frame_end = at_row_end && (row_ff == last_row(height_eff));
   assign emit         = col_ff[0] && row_ff[0];
   assign store_wr     = accept && col_ff[0] && !row_ff[0];
   assign slot         = col_ff[COL_W-1:1];

   // Pair the incoming pixel with the held even-column pixel
   assign pix.red    = req_chan.red_in;
   assign pix.green  = req_chan.green_in;
   assign pix.blue   = req_chan.blue_in;
   assign pair.red   = PAIR_W'(held_ff.red)   + PAIR_W'(pix.red);
   assign pair.green = PAIR_W'(held_ff.green) + PAIR_W'(pix.green);
   assign pair.blue  = PAIR_W'(held_ff.blue)  + PAIR_W'(pix.blue);

   // Add the stored pair sum above to the current one
   assign sum_red   = QUAD_W'(above_ff.red)   + QUAD_W'(s1_pair_ff.red);
   assign sum_green = QUAD_W'(above_ff.green) + QUAD_W'(s1_pair_ff.green);
   assign sum_blue  = QUAD_W'(above_ff.blue)  + QUAD_W'(s1_pair_ff.blue);

   // Next state for configuration, position and held pixel
   always_comb begin
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      held_in       = held_ff;
      if (csr_hit) begin
         if (csr_index == CSR_OUT_WIDTH) begin
            out_width_in = csr_wdata;
         end else begin
            out_height_in = csr_wdata;
         end
         col_in  = '0;
         row_in  = '0;
         held_in = '0;
      end else if (accept) begin
         if (!col_ff[0]) begin
            held_in = pix;
         end
         if (at_row_end) begin
            col_in = '0;
            row_in = at_frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Next state for the two pipeline stages
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pair_in   = s1_pair_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (s1_take) begin
         s1_valid_in = accept && emit;
         s1_pair_in  = pair;
         s1_last_in  = at_frame_end;
      end
      if (out_take) begin
         out_valid_in    = s1_valid_ff;
         out_pix_in.red   = sum_red[QUAD_W-1:2];
         out_pix_in.green = sum_green[QUAD_W-1:2];
         out_pix_in.blue  = sum_blue[QUAD_W-1:2];
         out_last_in     = s1_last_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= OUT_WIDTH_RESET;
         out_height_ff <= OUT_HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         held_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         held_ff       <= held_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_pair_ff  <= s1_pair_in;
      s1_last_ff  <= s1_last_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
   end

   // Line store: write on even rows, registered read on odd rows
   always_ff @(posedge clock) begin
      if (store_wr) begin
         line_store_ff[slot] <= pair;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         above_ff <= line_store_ff[slot];
      end
   end

   // Drive the result channel
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.red_out   = out_pix_ff.red;
   assign rsp_chan.green_out = out_pix_ff.green;
   assign rsp_chan.blue_out  = out_pix_ff.blue;
   assign rsp_chan.frame_end = out_last_ff;

endmodule

### rtl/core/rgbds_checker.sv
// Port-level checks for the 2x2 RGB box downsampler, bound to its top level.
`timescale 1ns / 1ps

module rgbds_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rgbds_pkg::PIX_W-1:0]    red_out,
   input logic [rgbds_pkg::PIX_W-1:0]    green_out,
   input logic [rgbds_pkg::PIX_W-1:0]    blue_out,
   input logic                           frame_end
);
   import rgbds_pkg::*;

   logic req_xfer;

   assign req_xfer = req_valid && req_ready;

   // Reset empties the output register
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A fresh result follows a pixel transfer through the first stage and output register
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_xfer, 2))
      else $error("result appeared without a matching pixel transfer");

   // An empty output stage never blocks the input
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register is empty");

   // Hold a stalled result
   a_result_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(red_out) &&
         $stable(green_out) && $stable(blue_out) && $stable(frame_end))
      else $error("stalled result changed");

endmodule

bind rgb_box_downsample_2x2 rgbds_checker u_rgbds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .red_out   (rsp_chan.red_out),
   .green_out (rsp_chan.green_out),
   .blue_out  (rsp_chan.blue_out),
   .frame_end (rsp_chan.frame_end)
);

### tb/rgb_box_downsample_2x2_tb.sv
// Self-checking bench for the 2x2 RGB box downsampler: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

module rgb_box_downsample_2x2_tb;
   import rgbds_pkg::*;

   // Register indexes that the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SPARE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_SPARE  = '1;

   localparam int    RANDOM_PIXELS = 620;
   localparam int    MAX_WAIT      = 13;
   localparam int    SETTLE_CYCLES = 4;
   localparam int    MAX_REPORTS   = 30;
   localparam longint RUN_LIMIT_NS = 10_000_000;

   typedef struct packed {
      pixel_type avg;
      logic      last;
   } avg_result_type;

   // Tracks the frame position and line store, and holds the averages still to come
   class box_scoreboard;
      logic [CFG_W-1:0] out_w;
      logic [CFG_W-1:0] out_h;
      pair_type         pair_row [MAX_OUT_WIDTH];
      pixel_type        held;
      int               col;
      int               row;
      avg_result_type   avg_queue [$];
      int               errors;
      int               pixels;
      int               results;
      int               frames;
      int               size_writes;

      function new();
         out_w = OUT_WIDTH_RESET;
         out_h = OUT_HEIGHT_RESET;
         foreach (pair_row[i]) pair_row[i] = '0;
         held        = '0;
         col         = 0;
         row         = 0;
         errors      = 0;
         pixels      = 0;
         results     = 0;
         frames      = 0;
         size_writes = 0;
      endfunction

      // Zero acts as one, anything above the maximum saturates
      function int effective(logic [CFG_W-1:0] v, int maxv);
         if (v == '0) return 1;
         if (int'(v) > maxv) return maxv;
         return int'(v);
      endfunction

      function int frame_pixels();
         return 4 * effective(out_w, MAX_OUT_WIDTH) * effective(out_h, MAX_OUT_HEIGHT);
      endfunction

      function int pending();
         return avg_queue.size();
      endfunction

      // A decoded register write restarts the frame; the line store is kept
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_OUT_WIDTH) begin
            out_w = val;
         end else if (idx == CSR_OUT_HEIGHT) begin
            out_h = val;
         end else begin
            return;
         end
         held = '0;
         col  = 0;
         row  = 0;
         size_writes++;
      endfunction

      function void note_pixel(pixel_type px);
         int             w;
         int             h;
         int             slot;
         pair_type       sum;
         pair_type       above;
         avg_result_type exp_avg;
         w    = effective(out_w, MAX_OUT_WIDTH);
         h    = effective(out_h, MAX_OUT_HEIGHT);
         slot = col / 2;
         pixels++;
         if (col % 2 == 0) begin
            held = px;
         end else begin
            sum.red   = PAIR_W'(held.red)   + PAIR_W'(px.red);
            sum.green = PAIR_W'(held.green) + PAIR_W'(px.green);
            sum.blue  = PAIR_W'(held.blue)  + PAIR_W'(px.blue);
            if (row % 2 == 0) begin
               pair_row[slot] = sum;
            end else begin
               // Odd row: add the pair above and truncate the quad sum
               above = pair_row[slot];
               exp_avg.avg.red   = PIX_W'((int'(above.red)   + int'(sum.red))   >> 2);
               exp_avg.avg.green = PIX_W'((int'(above.green) + int'(sum.green)) >> 2);
               exp_avg.avg.blue  = PIX_W'((int'(above.blue)  + int'(sum.blue))  >> 2);
               exp_avg.last      = (col == 2 * w - 1) && (row == 2 * h - 1);
               avg_queue.push_back(exp_avg);
            end
         end
         // Advance the raster position, wrapping at the frame end
         col++;
         if (col >= 2 * w) begin
            col = 0;
            row++;
            if (row >= 2 * h) row = 0;
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_avg(pixel_type got, logic got_last);
         avg_result_type want;
         if (avg_queue.size() == 0) begin
            report($sformatf("output %h last %b with nothing outstanding", got, got_last));
            return;
         end
         want = avg_queue.pop_front();
         results++;
         if (got.red !== want.avg.red)
            report($sformatf("output %0d red %0d, want %0d", results, got.red, want.avg.red));
         if (got.green !== want.avg.green)
            report($sformatf("output %0d green %0d, want %0d", results, got.green,
                             want.avg.green));
         if (got.blue !== want.avg.blue)
            report($sformatf("output %0d blue %0d, want %0d", results, got.blue, want.avg.blue));
         if (got_last !== want.last)
            report($sformatf("output %0d frame_end %b, want %b", results, got_last, want.last));
         if (want.last) frames++;
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   rgbds_req_if req_if ();
   rgbds_rsp_if rsp_if ();

   box_scoreboard sb = new();

   int send_run  = 0;
   bit send_calm = 1'b0;

   rgb_box_downsample_2x2 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw a wait in cycles; runs of calm items with no wait at all come now and then
   function automatic int draw_wait(inout int run_left, inout bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         calm     = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic pixel_type rgb(int r, int g, int b);
      pixel_type p;
      p.red   = PIX_W'(r);
      p.green = PIX_W'(g);
      p.blue  = PIX_W'(b);
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   // Offer one pixel after a random gap and hold it until the transfer
   task automatic send_pixel(pixel_type px);
      int gap;
      gap = draw_wait(send_run, send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.red_in   <= px.red;
      req_if.green_in <= px.green;
      req_if.blue_in  <= px.blue;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sb.note_pixel(px);
   endtask

   // Hold the sender off until every outstanding average has come back
   task automatic hold_for_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drain, then let the pipeline empty before touching the registers
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      settle();
      write_csr(CSR_OUT_WIDTH, w);
      write_csr(CSR_OUT_HEIGHT, h);
   endtask

   task automatic run_random(int n);
      for (int k = 0; k < n; k++) begin
         if (n > 1 && k == n / 2) hold_for_drain();
         send_pixel(random_pixel());
      end
   endtask

   // Result side: stall at random, then check each transfer
   initial begin
      int stall;
      int run_left;
      bit calm;
      run_left = 0;
      calm     = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(run_left, calm);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         sb.check_avg(rgb(rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out), rsp_if.frame_end);
      end
   end

   initial begin
      int               random_sent;
      int               frame_px;
      int               n;
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      req_if.valid    <= 1'b0;
      req_if.red_in   <= '0;
      req_if.green_in <= '0;
      req_if.blue_in  <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes: a full even row and the start of the odd row
      run_random(2 * int'(OUT_WIDTH_RESET) + 8);

      // Smallest frame: all ones, all zeros, truncation, then back-to-back frames
      configure(CFG_W'(1), CFG_W'(1));
      for (int i = 0; i < 4; i++) send_pixel(rgb(255, 255, 255));
      for (int i = 0; i < 4; i++) send_pixel(rgb(0, 0, 0));
      send_pixel(rgb(1, 2, 3));
      send_pixel(rgb(2, 3, 255));
      send_pixel(rgb(3, 255, 255));
      send_pixel(rgb(254, 255, 255));
      // Break off a frame half way and restart it with zero sizes
      send_pixel(rgb(128, 64, 32));
      send_pixel(rgb(7, 7, 7));
      configure(CFG_W'(0), CFG_W'(0));
      send_pixel(rgb(255, 0, 255));
      send_pixel(rgb(0, 255, 0));
      // A write to an undecoded index must leave the frame position alone
      settle();
      write_csr(CSR_LAST_SPARE, '1);
      send_pixel(rgb(255, 0, 255));
      send_pixel(rgb(0, 255, 0));

      // Random frames of small sizes, some cut short
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:             w = '0;
            1, 2, 3, 4, 5, 6: w = CFG_W'($urandom_range(1, 4));
            7, 8:          w = CFG_W'($urandom_range(5, 10));
            default:       w = CFG_W'($urandom_range(11, 24));
         endcase
         case ($urandom_range(0, 7))
            0:       h = '0;
            7:       h = CFG_W'($urandom_range(3, 4));
            default: h = CFG_W'($urandom_range(1, 2));
         endcase
         settle();
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_FIRST_SPARE, CSR_LAST_SPARE)),
                      CFG_W'($urandom_range(0, 2 ** CFG_W - 1)));
         case ($urandom_range(0, 5))
            0: write_csr(CSR_OUT_WIDTH, w);
            1: write_csr(CSR_OUT_HEIGHT, h);
            default: begin
               write_csr(CSR_OUT_WIDTH, w);
               write_csr(CSR_OUT_HEIGHT, h);
            end
         endcase
         frame_px = sb.frame_pixels();
         n = frame_px * ((frame_px > 96) ? 1 : $urandom_range(1, 3));
         if ($urandom_range(0, 2) == 0) n += $urandom_range(1, frame_px - 1);
         run_random(n);
         random_sent += n;
      end

      settle();
      $display("Sent %0d pixels; checked %0d averaged outputs and %0d frame ends.",
               sb.pixels, sb.results, sb.frames);
      $display("Applied %0d size writes, zero sizes among them, plus undecoded writes.",
               sb.size_writes);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule
